/* hdl/bmre_pkg.sv */
// Shared types and constants of the button matrix report engine.
`default_nettype none

package bmre_pkg;

    localparam int MASK_W      = 42;
    localparam int KEY_W       = 6;
    localparam int BTN_W       = 5;
    localparam int TICK_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MASK_W-1:0] SWITCH_MASK_RESET = 42'h30C00004000;
    localparam logic [KEY_W-1:0]  LEVEL_KEY_RESET   = 6'd16;
    localparam logic [TICK_W-1:0] BLINK_TICKS_RESET = 8'd2;
    localparam logic [TICK_W-1:0] PULSE_TICKS_RESET = 8'd200;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SWITCH_MASK   = 3'd0,
        REG_INVERTED_MASK = 3'd1,
        REG_LEVEL_KEY     = 3'd2,
        REG_LEVEL_INV     = 3'd3,
        REG_BLINK_MODE    = 3'd4,
        REG_BLINK_TICKS   = 3'd5,
        REG_PULSE_TICKS   = 3'd6
    } cfg_index_t;

    // Activity blink edge selection.
    typedef enum logic [1:0] {
        BLINK_ANY  = 2'd0,
        BLINK_RISE = 2'd1,
        BLINK_FALL = 2'd2,
        BLINK_NONE = 2'd3
    } blink_mode_t;

    // Kind of work handed from the front to the back.
    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_IGNORE = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic [MASK_W-1:0] switch_mask;
        logic [MASK_W-1:0] inverted_mask;
        logic [KEY_W-1:0]  level_led_key;
        logic              level_led_inverted;
        logic [1:0]        blink_edge_mode;
        logic [TICK_W-1:0] blink_ticks;
        logic [TICK_W-1:0] pulse_ticks;
    } cfg_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [KEY_W-1:0] key;
        logic             pressed;
        logic             switch_mode;
        logic             inverted;
        logic             blink_on_change;
        logic             level_match;
        logic             device_select;
        logic [BTN_W-1:0] button_number;
    } op_t;

endpackage

`default_nettype wire

/* hdl/button_matrix_report_engine.sv */
// Top level of the button matrix report engine.
`default_nettype none

// The engine takes one item per cycle: either a key sample from the scanned
// switch matrix (action 0) or a one-millisecond tick (action 1), and returns
// exactly one result per item, in order. A key sample produces a button report
// with its device, button number and value after the key's mode rules; a tick
// or a sample of a key outside the matrix produces a result whose report fields
// are zero. Both LED fields show the state after the item has been applied.
// Inside, a front stage classifies each item against the configuration and
// writes it into a two-entry queue; a back stage pops one operation per cycle
// unless the output holds its result, updates the per-key level, pulse flag and
// pulse countdown flops plus the blink countdown, and loads a result register.
// Sustained throughput is one transfer per cycle on both sides, set by the
// single back-stage update per cycle; each item passes through a queue entry
// and then the result register before its result is presented on the output.
// On a tick all per-key pulse countdowns drop in parallel in that same cycle.
// The input side and the output side stall independently: up to two items
// queue while the output is held. Configuration writes are always taken
// (cfg_ready is constant high) and must only be issued while the engine is idle.
module button_matrix_report_engine
    import bmre_pkg::*;
#(
    parameter int MATRIX_ROWS        = 7,
    parameter int MATRIX_COLUMNS     = 6,
    parameter int BUTTONS_PER_DEVICE = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   action,
    input  wire logic [KEY_W-1:0]       key_number,
    input  wire logic                   pressed,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        report_valid,
    output logic                        device_select,
    output logic [BTN_W-1:0]            button_number,
    output logic                        button_value,
    output logic                        blink_led,
    output logic                        level_led,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [MASK_W-1:0]      cfg_data
);

    localparam int KEY_COUNT = MATRIX_ROWS * MATRIX_COLUMNS;

    cfg_t cfg;
    op_t  front_op;
    op_t  head_op;
    logic queue_full;
    logic queue_empty;
    logic op_take;

    // Configuration writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;

    bmre_config u_config (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bmre_front #(
        .KEY_COUNT          (KEY_COUNT),
        .BUTTONS_PER_DEVICE (BUTTONS_PER_DEVICE)
    ) u_front (
        .action     (action),
        .key_number (key_number),
        .pressed    (pressed),
        .cfg        (cfg),
        .op         (front_op)
    );

    // The input is held off only when the queue has no free entry.
    assign in_stall = queue_full;

    bmre_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_valid && !queue_full),
        .push_op (front_op),
        .pop     (op_take),
        .head_op (head_op),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    bmre_back #(
        .KEY_COUNT (KEY_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .op            (head_op),
        .op_avail      (!queue_empty),
        .op_take       (op_take),
        .res_valid     (out_valid),
        .res_stall     (out_stall),
        .report_valid  (report_valid),
        .device_select (device_select),
        .button_number (button_number),
        .button_value  (button_value),
        .blink_led     (blink_led),
        .level_led     (level_led)
    );

endmodule

`default_nettype wire

/* hdl/bmre_config.sv */
// Configuration register file of the button matrix report engine.
`default_nettype none

module bmre_config
    import bmre_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [MASK_W-1:0]      wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SWITCH_MASK:   cfg_next.switch_mask        = wr_data;
                REG_INVERTED_MASK: cfg_next.inverted_mask      = wr_data;
                REG_LEVEL_KEY:     cfg_next.level_led_key      = wr_data[KEY_W-1:0];
                REG_LEVEL_INV:     cfg_next.level_led_inverted = wr_data[0];
                REG_BLINK_MODE:    cfg_next.blink_edge_mode    = wr_data[1:0];
                REG_BLINK_TICKS:   cfg_next.blink_ticks        = wr_data[TICK_W-1:0];
                REG_PULSE_TICKS:   cfg_next.pulse_ticks        = wr_data[TICK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.switch_mask        <= SWITCH_MASK_RESET;
            cfg_reg.inverted_mask      <= '0;
            cfg_reg.level_led_key      <= LEVEL_KEY_RESET;
            cfg_reg.level_led_inverted <= 1'b0;
            cfg_reg.blink_edge_mode    <= BLINK_ANY;
            cfg_reg.blink_ticks        <= BLINK_TICKS_RESET;
            cfg_reg.pulse_ticks        <= PULSE_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/bmre_front.sv */
// Front stage: classifies an incoming sample or tick into an operation.
`default_nettype none

module bmre_front
    import bmre_pkg::*;
#(
    parameter int KEY_COUNT          = 42,
    parameter int BUTTONS_PER_DEVICE = 32
)
(
    input  wire logic             action,
    input  wire logic [KEY_W-1:0] key_number,
    input  wire logic             pressed,
    input  cfg_t                  cfg,
    output op_t                   op
);

    localparam int CMP_W = 9;
    localparam int REM_W = 8;
    localparam int REM_STEPS = 8;

    logic [REM_W-1:0] rem;
    logic             in_range;

    // Key number modulo the device size. Each multiple of the device size from one
    // to seven times it is compared against the key on its own, and the largest multiple that fits
    // is subtracted, so no subtraction waits on another.
    always_comb
    begin
        rem = REM_W'(key_number);
        for (int i = 1; i < REM_STEPS; i++)
        begin
            if (int'(key_number) >= i * BUTTONS_PER_DEVICE)
            begin
                rem = REM_W'(int'(key_number) - i * BUTTONS_PER_DEVICE);
            end
        end
    end

    assign in_range = CMP_W'(key_number) < CMP_W'(KEY_COUNT);

    always_comb
    begin
        op.key           = key_number;
        op.pressed       = pressed;
        op.switch_mode   = 1'b0;
        op.inverted      = 1'b0;
        op.level_match   = key_number == cfg.level_led_key;
        op.device_select = REM_W'(key_number) >= REM_W'(BUTTONS_PER_DEVICE);
        op.button_number = rem[BTN_W-1:0];

        if (key_number < KEY_W'(MASK_W))
        begin
            op.switch_mode = cfg.switch_mask[key_number];
            op.inverted    = cfg.inverted_mask[key_number];
        end

        case (cfg.blink_edge_mode)
            BLINK_ANY:  op.blink_on_change = 1'b1;
            BLINK_RISE: op.blink_on_change = pressed;
            BLINK_FALL: op.blink_on_change = !pressed;
            default:    op.blink_on_change = 1'b0;
        endcase

        if (action)
        begin
            op.kind = OP_TICK;
        end
        else if (in_range)
        begin
            op.kind = OP_SAMPLE;
        end
        else
        begin
            op.kind = OP_IGNORE;
        end
    end

endmodule

`default_nettype wire

/* hdl/bmre_queue.sv */
// Short operation queue between the front and the back.
`default_nettype none

module bmre_queue
    import bmre_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_op,
    input  wire logic pop,
    output op_t       head_op,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign head_op = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

/* hdl/bmre_back.sv */
// Back stage: per-key state, countdowns, LEDs and the result register.
`default_nettype none

module bmre_back
    import bmre_pkg::*;
#(
    parameter int KEY_COUNT = 42
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  cfg_t                   cfg,
    input  op_t                    op,
    input  wire logic              op_avail,
    output logic                   op_take,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output logic                   report_valid,
    output logic                   device_select,
    output logic [BTN_W-1:0]       button_number,
    output logic                   button_value,
    output logic                   blink_led,
    output logic                   level_led
);

    localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic              prev_reg  [KEY_COUNT];
    logic              sent_reg  [KEY_COUNT];
    logic [TICK_W-1:0] pulse_reg [KEY_COUNT];
    logic [TICK_W-1:0] blink_cnt_reg;
    logic [TICK_W-1:0] blink_cnt_next;
    logic              led_state_reg;
    logic              led_state_next;

    logic              out_valid_reg;
    logic              report_valid_reg;
    logic              device_select_reg;
    logic [BTN_W-1:0]  button_number_reg;
    logic              button_value_reg;
    logic              blink_led_reg;
    logic              level_led_reg;

    logic [KEY_IDX_W-1:0] idx;
    logic                 is_tick;
    logic                 is_sample;
    logic                 changed;
    logic                 restart;
    logic [TICK_W-1:0]    pulse_k;
    logic                 sent_k;
    logic                 value;

    assign op_take   = op_avail && (!out_valid_reg || !res_stall);
    assign idx       = KEY_IDX_W'(op.key);
    assign is_tick   = op_take && (op.kind == OP_TICK);
    assign is_sample = op_take && (op.kind == OP_SAMPLE);

    always_comb
    begin
        changed  = op.pressed != prev_reg[idx];
        restart  = changed && op.switch_mode;
        pulse_k  = restart ? cfg.pulse_ticks : pulse_reg[idx];
        sent_k   = restart ? 1'b0 : sent_reg[idx];

        if (op.switch_mode)
        begin
            value = (pulse_k != '0) || !sent_k;
        end
        else
        begin
            value = op.pressed ^ op.inverted;
        end

        blink_cnt_next = blink_cnt_reg;
        led_state_next = led_state_reg;
        if (is_tick)
        begin
            if (blink_cnt_reg != '0)
            begin
                blink_cnt_next = blink_cnt_reg - 1'b1;
            end
        end
        else if (is_sample)
        begin
            if (changed && op.blink_on_change)
            begin
                blink_cnt_next = cfg.blink_ticks;
            end
            if (op.level_match)
            begin
                led_state_next = op.pressed ^ cfg.level_led_inverted;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                prev_reg[i]  <= 1'b0;
                sent_reg[i]  <= 1'b0;
                pulse_reg[i] <= '0;
            end
            blink_cnt_reg <= '0;
            led_state_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < KEY_COUNT; i++)
            begin
                if (is_tick)
                begin
                    if (pulse_reg[i] != '0)
                    begin
                        pulse_reg[i] <= pulse_reg[i] - 1'b1;
                    end
                end
                else if (is_sample && (idx == KEY_IDX_W'(i)))
                begin
                    prev_reg[i]  <= op.pressed;
                    pulse_reg[i] <= pulse_k;
                    sent_reg[i]  <= op.switch_mode ? 1'b1 : sent_k;
                end
            end
            blink_cnt_reg <= blink_cnt_next;
            led_state_reg <= led_state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            report_valid_reg  <= op.kind == OP_SAMPLE;
            device_select_reg <= (op.kind == OP_SAMPLE) && op.device_select;
            button_number_reg <= (op.kind == OP_SAMPLE) ? op.button_number : '0;
            button_value_reg  <= (op.kind == OP_SAMPLE) && value;
            blink_led_reg     <= blink_cnt_next != '0;
            level_led_reg     <= led_state_next;
        end
    end

    assign res_valid     = out_valid_reg;
    assign report_valid  = report_valid_reg;
    assign device_select = device_select_reg;
    assign button_number = button_number_reg;
    assign button_value  = button_value_reg;
    assign blink_led     = blink_led_reg;
    assign level_led     = level_led_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !report_valid_reg |->
            !device_select_reg && (button_number_reg == '0) && !button_value_reg)
        else $error("result without report carries button fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(op_take) |-> blink_led_reg == (blink_cnt_reg != '0))
        else $error("activity LED does not match blink countdown");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(op_take) |-> level_led_reg == led_state_reg)
        else $error("second LED does not match its state");

endmodule

`default_nettype wire
